FILE: hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned ROUNDS      = 64;

  typedef logic [31:0]                  word_t;
  typedef logic [BLOCK_WORDS-1:0][31:0] block_t;
  typedef logic [HASH_WORDS-1:0][31:0]  hash_t;

  typedef struct packed {
    logic start;
    logic clear;
  } core_ctl_t;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS       = 6'd56;
  localparam logic [5:0] LAST_POS      = 6'd63;
  localparam logic [63:0] BYTE_BITS    = 64'd8;

  // index 0 is H0
  localparam hash_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t big_s0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_s1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_s0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_s1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t pick(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t major(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

FILE: hw/rtl/sha256_core.sv
// ----------------------------------------------------------------------------
// sha256_core
// Compression unit: one round per cycle over a rolling 16-word schedule,
// then a final add into the chaining hash.
// ----------------------------------------------------------------------------
module sha256_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256_pkg::core_ctl_t ctl,
  input  sha256_pkg::block_t    blk,
  output logic                  done,
  output sha256_pkg::hash_t     hash
);
  import sha256_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} cstate_t;

  localparam logic [5:0] ROUND_LAST = 6'(ROUNDS - 1);

  cstate_t    state_r;
  logic [5:0] rnd_r;
  logic       done_r;
  hash_t      hash_r;
  block_t     w_r;
  hash_t      v_r;

  word_t t1;
  word_t t2;
  word_t w_new;

  always_comb begin
    t1    = v_r[7] + big_s1(v_r[4]) + pick(v_r[4], v_r[5], v_r[6]) + round_k(rnd_r) + w_r[0];
    t2    = big_s0(v_r[0]) + major(v_r[0], v_r[1], v_r[2]);
    w_new = small_s1(w_r[14]) + w_r[9] + small_s0(w_r[1]) + w_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= '0;
      done_r  <= 1'b0;
      hash_r  <= H_INIT;
    end else begin
      done_r <= 1'b0;
      if (ctl.clear) begin
        hash_r <= H_INIT;
      end
      case (state_r)
        C_IDLE: begin
          if (ctl.start) begin
            w_r     <= blk;
            v_r     <= hash_r;
            rnd_r   <= '0;
            state_r <= C_ROUND;
          end
        end
        C_ROUND: begin
          v_r[0] <= t1 + t2;
          v_r[1] <= v_r[0];
          v_r[2] <= v_r[1];
          v_r[3] <= v_r[2];
          v_r[4] <= v_r[3] + t1;
          v_r[5] <= v_r[4];
          v_r[6] <= v_r[5];
          v_r[7] <= v_r[6];
          w_r    <= {w_new, w_r[BLOCK_WORDS-1:1]};
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == ROUND_LAST) begin
            state_r <= C_FINAL;
          end
        end
        C_FINAL: begin
          for (int i = 0; i < HASH_WORDS; i++) begin
            hash_r[i] <= hash_r[i] + v_r[i];
          end
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign hash = hash_r;

endmodule

FILE: hw/rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher
// Byte-serial SHA-256: gathers bytes into blocks, pads and emits the digest.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per handshake; in_byte_data is taken when in_has_byte is
//           set, in_is_last closes the message (an item with neither flag
//           does nothing, one with only in_is_last closes an empty message).
//   out_* : eight items per message, word 0 (H0) first, out_last_word on the
//           eighth; the words hold steady while out_ready is low.
// Rate:
//   one byte per cycle while a block is being filled; after every 64th byte
//   in_ready drops while the core runs (start, 64 rounds at one per cycle,
//   final add, hand back). At message end the padding goes in one byte per
//   cycle, pausing while a full block is compressed; it takes one or two
//   compressions, then the digest is offered.
// Reset:
//   synchronous, active low; the hash returns to the initial values and the
//   byte position and bit count clear. After the eighth word is taken the
//   block reinitializes and accepts the next message.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_data,
  input  logic        in_has_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha256_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_COMP, S_PAD, S_OUT} state_t;
  typedef enum logic [1:0] {P_MARK, P_ZERO, P_LEN, P_DONE} pad_t;

  state_t      state_r;
  pad_t        phase_r;
  logic        pad_r;
  logic [5:0]  pos_r;
  logic [2:0]  len_idx_r;
  logic [63:0] bit_cnt_r;
  logic [2:0]  widx_r;
  core_ctl_t   ctl_r;
  block_t      blk_r;

  logic        in_fire;
  logic        out_fire;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [7:0]  pad_byte;
  logic [5:0]  pos_inc;
  logic        blk_full;
  logic        core_done;
  hash_t       core_hash;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    case (phase_r)
      P_MARK:  pad_byte = PAD_MARK_BYTE;
      P_LEN:   pad_byte = bit_cnt_r[{~len_idx_r, 3'b000} +: 8];
      default: pad_byte = 8'h00;
    endcase
    wr_en    = (in_fire && in_has_byte) || (state_r == S_PAD);
    wr_byte  = (state_r == S_PAD) ? pad_byte : in_byte_data;
    pos_inc  = pos_r + 6'd1;
    blk_full = wr_en && (pos_r == LAST_POS);
  end

  // big-endian byte lanes within each word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_r[pos_r[5:2]][{~pos_r[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= P_MARK;
      pad_r     <= 1'b0;
      pos_r     <= '0;
      len_idx_r <= '0;
      bit_cnt_r <= '0;
      widx_r    <= '0;
      ctl_r     <= '0;
    end else begin
      ctl_r.start <= blk_full;
      ctl_r.clear <= 1'b0;
      if (wr_en) begin
        pos_r <= pos_inc;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_has_byte) begin
              bit_cnt_r <= bit_cnt_r + BYTE_BITS;
            end
            if (in_is_last) begin
              pad_r     <= 1'b1;
              phase_r   <= P_MARK;
              len_idx_r <= '0;
            end
            if (blk_full) begin
              state_r <= S_COMP;
            end else if (in_is_last) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          case (phase_r)
            P_MARK, P_ZERO: begin
              phase_r <= (pos_inc == LEN_POS) ? P_LEN : P_ZERO;
            end
            P_LEN: begin
              len_idx_r <= len_idx_r + 3'd1;
              if (len_idx_r == 3'd7) begin
                phase_r <= P_DONE;
              end
            end
            default: begin
              phase_r <= P_DONE;
            end
          endcase
          if (blk_full) begin
            state_r <= S_COMP;
          end
        end
        S_COMP: begin
          if (core_done) begin
            if (!pad_r) begin
              state_r <= S_IDLE;
            end else if (phase_r == P_DONE) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_PAD;
            end
          end
        end
        S_OUT: begin
          if (out_fire) begin
            widx_r <= widx_r + 3'd1;
            if (widx_r == 3'd7) begin
              state_r     <= S_IDLE;
              pad_r       <= 1'b0;
              phase_r     <= P_MARK;
              bit_cnt_r   <= '0;
              ctl_r.clear <= 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  sha256_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_r),
    .blk   (blk_r),
    .done  (core_done),
    .hash  (core_hash)
  );

  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = core_hash[widx_r];
  assign out_word_index  = widx_r;
  assign out_last_word   = (widx_r == 3'd7);

endmodule
